// ===== rtl/hpg_pkg.sv =====
// shared constants, prime table and control structs of the halton point generator
// no dependencies

package hpg_pkg;

  localparam int INDEX_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 24;

  localparam int DIM_W      = 4;
  localparam int NUM_PRIMES = 16;
  localparam int PRIME_W    = 6;
  localparam int BOUND_W    = 32;
  localparam int SPAN_W     = 32;
  localparam int VALUE_W    = 34;

  localparam logic [PRIME_W-1:0] PRIMES [NUM_PRIMES] = '{
    6'd2,  6'd3,  6'd5,  6'd7,  6'd11, 6'd13, 6'd17, 6'd19,
    6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47, 6'd53
  };

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic digit_mul;
    logic digit_fix;
    logic div_step;
    logic scale;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic index_zero;
  } status_t;

endpackage

// ===== rtl/hpg_datapath.sv =====
// datapath: digit extraction by reciprocal multiply, reversed integer build,
// bit-serial long division and span scaling; uses hpg_pkg

module hpg_datapath #(
  parameter int INDEX_BITS    = hpg_pkg::INDEX_BITS_DEF,
  parameter int FRACTION_BITS = hpg_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hpg_pkg::cmd_t                     cmd,
  output hpg_pkg::status_t                  status,
  input  logic [INDEX_BITS-1:0]             sample_index,
  input  logic [hpg_pkg::DIM_W-1:0]         dimension,
  input  logic signed [hpg_pkg::BOUND_W-1:0] lower_bound,
  input  logic [hpg_pkg::SPAN_W-1:0]        span,
  input  logic                              last_sample,
  output logic signed [hpg_pkg::VALUE_W-1:0] value,
  output logic [FRACTION_BITS-1:0]          fraction,
  output logic [hpg_pkg::DIM_W-1:0]         dimension_out,
  output logic                              last_out
);

  localparam int PW     = hpg_pkg::PRIME_W;
  localparam int NUM_W  = INDEX_BITS + PW;
  localparam logic [63:0] SCALE = 64'd1 << INDEX_BITS;

  // floor(2^INDEX_BITS / prime), quotient estimate is low by at most one
  logic [INDEX_BITS-1:0] recip_tab [hpg_pkg::NUM_PRIMES];

  for (genvar g = 0; g < hpg_pkg::NUM_PRIMES; g++) begin : g_recip
    localparam logic [63:0] M = SCALE / 64'(hpg_pkg::PRIMES[g]);
    assign recip_tab[g] = M[INDEX_BITS-1:0];
  end

  logic [INDEX_BITS-1:0]         x;
  logic [INDEX_BITS-1:0]         recip;
  logic [PW-1:0]                 base;
  logic [2*INDEX_BITS-1:0]       prod;
  logic [PW-1:0]                 digit;
  logic                          have_digit;
  logic [NUM_W-1:0]              rev;
  logic [NUM_W-1:0]              den;
  logic [FRACTION_BITS-1:0]      quo;
  logic [hpg_pkg::SPAN_W-1:0]    span_r;
  logic [hpg_pkg::SPAN_W-1:0]    scaled;
  logic signed [hpg_pkg::BOUND_W-1:0] bound_r;
  logic [hpg_pkg::DIM_W-1:0]     dim_r;
  logic                          last_r;

  logic [NUM_W-1:0]              base_ext;
  logic [INDEX_BITS-1:0]         q_est;
  logic [NUM_W-1:0]              qb;
  logic [NUM_W-1:0]              rem_full;
  logic [PW:0]                   rem;
  logic                          rem_over;
  logic [NUM_W:0]                rev_dbl;
  logic                          div_ge;
  logic [FRACTION_BITS+hpg_pkg::SPAN_W-1:0] span_prod;

  assign status.index_zero = (x == '0);

  assign base_ext  = {{(NUM_W-PW){1'b0}}, base};
  assign q_est     = prod[2*INDEX_BITS-1:INDEX_BITS];
  assign qb        = NUM_W'({{PW{1'b0}}, q_est} * base_ext);
  assign rem_full  = {{PW{1'b0}}, x} - qb;
  assign rem       = rem_full[PW:0];
  assign rem_over  = (rem >= {1'b0, base});
  assign rev_dbl   = {rev, 1'b0};
  assign div_ge    = (rev_dbl >= {1'b0, den});
  assign span_prod = {{hpg_pkg::SPAN_W{1'b0}}, quo} * {{FRACTION_BITS{1'b0}}, span_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      have_digit <= 1'b0;
    end else if (cmd.load) begin
      have_digit <= 1'b0;
    end else if (cmd.digit_fix) begin
      have_digit <= 1'b1;
    end else if (cmd.digit_mul) begin
      have_digit <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x       <= sample_index;
      recip   <= recip_tab[dimension];
      base    <= hpg_pkg::PRIMES[dimension];
      rev     <= '0;
      den     <= NUM_W'(1);
      quo     <= '0;
      span_r  <= span;
      bound_r <= lower_bound;
      dim_r   <= dimension;
      last_r  <= last_sample;
    end
    if (cmd.digit_mul) begin
      prod <= {{INDEX_BITS{1'b0}}, x} * {{INDEX_BITS{1'b0}}, recip};
      // fold in the digit found last step
      if (have_digit) begin
        rev <= NUM_W'(rev * base_ext) + NUM_W'(digit);
        den <= NUM_W'(den * base_ext);
      end
    end
    if (cmd.digit_fix) begin
      if (rem_over) begin
        digit <= PW'(rem - {1'b0, base});
        x     <= q_est + INDEX_BITS'(1);
      end else begin
        digit <= rem[PW-1:0];
        x     <= q_est;
      end
    end
    if (cmd.div_step) begin
      // rev holds the running remainder during the division
      rev <= div_ge ? NUM_W'(rev_dbl - {1'b0, den}) : rev_dbl[NUM_W-1:0];
      quo <= {quo[FRACTION_BITS-2:0], div_ge};
    end
    if (cmd.scale) begin
      scaled <= span_prod[FRACTION_BITS+hpg_pkg::SPAN_W-1:FRACTION_BITS];
    end
    if (cmd.emit) begin
      value         <= {{2{bound_r[hpg_pkg::BOUND_W-1]}}, bound_r}
                       + $signed({2'b00, scaled});
      fraction      <= quo;
      dimension_out <= dim_r;
      last_out      <= last_r;
    end
  end

endmodule

// ===== rtl/hpg_controller.sv =====
// controller: sequences digit steps, division bits, scaling and the output slot
// uses hpg_pkg command and status structs

module hpg_controller #(
  parameter int FRACTION_BITS = hpg_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  hpg_pkg::status_t status,
  output hpg_pkg::cmd_t    cmd
);

  localparam int CNT_W = $clog2(FRACTION_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIG,
    S_DIV,
    S_SCALE,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             slot_free;

  assign slot_free = !out_valid || out_ready;
  // no request is taken while reset is held
  assign in_ready  = (state == S_IDLE) && !rst;

  always_comb begin
    cmd           = '0;
    cmd.load      = in_ready && in_valid;
    cmd.digit_mul = (state == S_MUL);
    cmd.digit_fix = (state == S_DIG);
    cmd.div_step  = (state == S_DIV);
    cmd.scale     = (state == S_SCALE);
    cmd.emit      = (state == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_MUL;
        end
        S_MUL: begin
          if (status.index_zero) begin
            state <= S_DIV;
            cnt   <= '0;
          end else begin
            state <= S_DIG;
          end
        end
        S_DIG: begin
          state <= S_MUL;
        end
        S_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(FRACTION_BITS - 1)) state <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/halton_point_generator_core.sv =====
// top level of the halton point generator: controller plus datapath
// uses hpg_pkg, hpg_controller, hpg_datapath

// One request gives one coordinate of a Halton point: the index is written in the
// prime base picked by the dimension, one digit at a time (reciprocal
// multiply, then correction), then the radical inverse is found by long division
// one fraction bit per cycle, then scaled by span and offset by lower_bound.
// One request is in work at a time; a finished result sits in an output register,
// so the next request is taken while the previous result waits to be read.

module halton_point_generator_core #(
  parameter int INDEX_BITS    = hpg_pkg::INDEX_BITS_DEF,
  parameter int FRACTION_BITS = hpg_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [INDEX_BITS-1:0]              sample_index,
  input  logic [hpg_pkg::DIM_W-1:0]          dimension,
  input  logic signed [hpg_pkg::BOUND_W-1:0] lower_bound,
  input  logic [hpg_pkg::SPAN_W-1:0]         span,
  input  logic                               last_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hpg_pkg::VALUE_W-1:0] value,
  output logic [FRACTION_BITS-1:0]           fraction,
  output logic [hpg_pkg::DIM_W-1:0]          dimension_out,
  output logic                               last_out
);

  hpg_pkg::cmd_t    cmd;
  hpg_pkg::status_t status;

  hpg_controller #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hpg_datapath #(
    .INDEX_BITS    (INDEX_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .sample_index  (sample_index),
    .dimension     (dimension),
    .lower_bound   (lower_bound),
    .span          (span),
    .last_sample   (last_sample),
    .value         (value),
    .fraction      (fraction),
    .dimension_out (dimension_out),
    .last_out      (last_out)
  );

endmodule

// ===== tb/sv/tb_halton_point_generator_core.sv =====
// testbench of halton_point_generator_core: directed table, then random batches of coordinates
// depends on hpg_pkg and the rtl of halton_point_generator_core

module tb_halton_point_generator_core;

  localparam int INDEX_W        = hpg_pkg::INDEX_BITS_DEF;
  localparam int FRAC_W         = hpg_pkg::FRACTION_BITS_DEF;
  localparam int DIM_W          = hpg_pkg::DIM_W;
  localparam int VALUE_W        = hpg_pkg::VALUE_W;
  localparam int RANDOM_ITEMS   = 1025;
  localparam int CALM_ITEMS     = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AFTER     = 150;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam longint unsigned BASES [16] = '{
    2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53
  };

  typedef struct {
    logic [INDEX_W-1:0]              index;
    logic [DIM_W-1:0]                dim;
    logic signed [hpg_pkg::BOUND_W-1:0] lower;
    logic [hpg_pkg::SPAN_W-1:0]      span;
    logic                            last;
    bit                              typed;
    logic signed [VALUE_W-1:0]       typed_value;
    logic [FRAC_W-1:0]               typed_fraction;
  } request_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [FRAC_W-1:0]         fraction;
    logic [DIM_W-1:0]          dim;
    logic                      last;
  } point_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [INDEX_W-1:0]                 sample_index = '0;
  logic [DIM_W-1:0]                   dimension = '0;
  logic signed [hpg_pkg::BOUND_W-1:0] lower_bound = '0;
  logic [hpg_pkg::SPAN_W-1:0]         span = '0;
  logic                               last_sample = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [VALUE_W-1:0]          value;
  logic [FRAC_W-1:0]                  fraction;
  logic [DIM_W-1:0]                   dimension_out;
  logic                               last_out;

  // typed expectation that travels with the request on the bus
  bit                        cur_typed = 1'b0;
  logic signed [VALUE_W-1:0] cur_typed_value = '0;
  logic [FRAC_W-1:0]         cur_typed_fraction = '0;

  point_t   pending_points [$];
  request_t directed_rows [$];
  int       mismatches = 0;
  int       requests_taken = 0;
  int       points_checked = 0;
  int       quiet_cycles = 0;
  int       idle_pct = 15;
  bit       calm = 1'b0;
  int       hold_seen = 0;
  bit [15:0] dims_seen = '0;

  halton_point_generator_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_index  (sample_index),
    .dimension     (dimension),
    .lower_bound   (lower_bound),
    .span          (span),
    .last_sample   (last_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .value         (value),
    .fraction      (fraction),
    .dimension_out (dimension_out),
    .last_out      (last_out)
  );

  always #5 clk = ~clk;

  // radical inverse by exact long division, then scale and offset
  function automatic point_t predict_point(request_t r);
    point_t          p;
    longint unsigned n, b, rev, den, rem, q, scaled;
    longint          lo_ext;
    n   = r.index;
    b   = BASES[r.dim];
    rev = 0;
    den = 1;
    q   = 0;
    while (n > 0) begin
      rev = rev * b + (n % b);
      den = den * b;
      n   = n / b;
    end
    rem = rev;
    for (int i = 0; i < FRAC_W; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 1;
      end
    end
    scaled     = (q * longint'(r.span)) >> FRAC_W;
    lo_ext     = r.lower;
    p.value    = VALUE_W'(lo_ext + longint'(scaled));
    p.fraction = FRAC_W'(q);
    p.dim      = r.dim;
    p.last     = r.last;
    return p;
  endfunction

  task automatic add_row(input int idx, input int dim, input logic [31:0] lo,
                         input logic [31:0] sp, input bit last, input bit typed,
                         input longint tv, input int tf);
    request_t r;
    r.index          = INDEX_W'(idx);
    r.dim            = DIM_W'(dim);
    r.lower          = lo;
    r.span           = sp;
    r.last           = last;
    r.typed          = typed;
    r.typed_value    = VALUE_W'(tv);
    r.typed_fraction = FRAC_W'(tf);
    directed_rows = {directed_rows, r};
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // drive one request from a falling edge and hold it until it is taken
  task automatic offer_request(input request_t r);
    if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    sample_index       = r.index;
    dimension          = r.dim;
    lower_bound        = r.lower;
    span               = r.span;
    last_sample        = r.last;
    cur_typed          = r.typed;
    cur_typed_value    = r.typed_value;
    cur_typed_fraction = r.typed_fraction;
    in_valid           = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [INDEX_W-1:0] pick_index(input int dim);
    longint unsigned p, b;
    int              n;
    b = BASES[dim];
    case ($urandom_range(0, 5))
      0: return INDEX_W'($urandom_range(0, 15));
      1: return INDEX_W'($urandom_range(0, 255));
      2: return $urandom_range(0, 1) ? '1 : '0;
      3: begin
        // land on or just below a power of the base
        p = 1;
        n = $urandom_range(1, 16);
        while (n > 0 && p * b <= 65535) begin
          p = p * b;
          n--;
        end
        return INDEX_W'(p - $urandom_range(0, 1));
      end
      default: return INDEX_W'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_lower();
    case ($urandom_range(0, 4))
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(0, 32'h20000)) - 32'h10000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 4))
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return {16'($urandom_range(0, 255)), 16'h0};
      default: return $urandom;
    endcase
  endfunction

  // monitor: predict on request accept, check on result accept, watchdog
  always @(posedge clk) begin
    request_t r;
    point_t   e;
    point_t   p;
    if (in_valid && in_ready && !rst) begin
      r.index  = sample_index;
      r.dim    = dimension;
      r.lower  = lower_bound;
      r.span   = span;
      r.last   = last_sample;
      p = predict_point(r);
      if (cur_typed) begin
        p.value    = cur_typed_value;
        p.fraction = cur_typed_fraction;
      end
      pending_points = {pending_points, p};
      dims_seen[dimension] = 1'b1;
      requests_taken++;
    end
    if (out_valid && out_ready && !rst) begin
      if (pending_points.size() == 0) begin
        note_mismatch($sformatf("result with no request waiting: value %0d fraction %h",
                                value, fraction));
      end else begin
        e = pending_points.pop_front();
        if (value !== e.value || fraction !== e.fraction ||
            dimension_out !== e.dim || last_out !== e.last)
          note_mismatch($sformatf(
            "exp value %0d frac %h dim %0d last %b, got value %0d frac %h dim %0d last %b",
            e.value, e.fraction, e.dim, e.last, value, fraction, dimension_out, last_out));
      end
      points_checked++;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_points.size());
        $display("[halton_point_generator_core] ERROR");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold-off so the block backs up
  initial begin
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_seen == 0 && points_checked >= HOLD_AFTER) begin
        out_ready = 1'b0;
        while (hold_seen < HOLD_CYCLES) begin
          @(negedge clk);
          hold_seen++;
        end
      end
      if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_ready = 1'b1;
    end
  end

  initial begin
    request_t r;
    int       sent;
    int       batch;
    int       shared_index;
    int       pct_steps [3];
    pct_steps = '{0, 15, 40};

    // index zero gives a zero fraction, index 1 and 2 in base 2 give 1/2 and 1/4
    add_row(0, 0, 32'h0, 32'h0, 0, 1, 0, 0);
    add_row(0, 15, 32'h8000_0000, 32'hffff_ffff, 0, 1, -64'sd2147483648, 0);
    add_row(0, 7, 32'h7fff_ffff, 32'hffff_ffff, 1, 1, 64'sd2147483647, 0);
    add_row(1, 0, 32'h0, 32'h0001_0000, 0, 1, 64'h8000, 24'h80_0000);
    add_row(1, 0, 32'h7fff_ffff, 32'hffff_ffff, 0, 1, 64'd4294967294, 24'h80_0000);
    add_row(1, 0, 32'h8000_0000, 32'h0, 1, 1, -64'sd2147483648, 24'h80_0000);
    add_row(2, 0, 32'h0, 32'h0, 0, 1, 0, 24'h40_0000);
    add_row(16'h8000, 0, 32'h0, 32'h0, 0, 1, 0, 24'h00_0100);
    add_row(16'haaaa, 1, 32'hffff_ffff, 32'h1234_5678, 1, 0, 0, 0);
    // full index in every base
    for (int d = 0; d < 16; d++)
      add_row(16'hffff, d, (d % 2) ? 32'h8000_0000 : 32'h7fff_ffff, 32'hffff_ffff,
              d == 15, 0, 0, 0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) offer_request(directed_rows[i]);

    // random part: mostly whole points, dimensions in order, last on the final one
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        r.index = INDEX_W'($urandom);
        r.dim   = DIM_W'($urandom_range(0, 15));
        r.index = pick_index(r.dim);
        r.lower = pick_lower();
        r.span  = pick_span();
        r.last  = 1'($urandom_range(0, 1));
        r.typed = 1'b0;
        idle_pct = pct_steps[(sent / 100) % 3];
        calm     = sent >= RANDOM_ITEMS - CALM_ITEMS;
        offer_request(r);
        sent++;
      end else begin
        batch        = $urandom_range(1, 16);
        shared_index = pick_index($urandom_range(0, 15));
        for (int d = 0; d < batch && sent < RANDOM_ITEMS; d++) begin
          r.index = INDEX_W'(shared_index);
          r.dim   = DIM_W'(d);
          r.lower = pick_lower();
          r.span  = pick_span();
          r.last  = (d == batch - 1) || (sent == RANDOM_ITEMS - 1);
          r.typed = 1'b0;
          idle_pct = pct_steps[(sent / 100) % 3];
          calm     = sent >= RANDOM_ITEMS - CALM_ITEMS;
          offer_request(r);
          sent++;
        end
      end
    end
    in_valid  = 1'b0;
    cur_typed = 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests (%0d from the table) and %0d results, dimensions seen %h",
             requests_taken, directed_rows.size(), points_checked, dims_seen);
    $display("output side held off for %0d cycles once; %0d mismatches",
             hold_seen, mismatches);
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("[halton_point_generator_core] OK");
    end else begin
      $display("[halton_point_generator_core] ERROR");
    end
    $finish;
  end

endmodule
